// ===== sv/rmc_pkg.sv =====
// Package for the RMC sentence field extractor.
// Holds character codes, result kinds, field ids, the result struct and
// header/field decode functions. No dependencies.
package rmc_pkg;

    localparam int MAX_SENTENCE_DEF = 80;
    localparam int FIELD_CHARS_DEF  = 12;

    localparam int HDR_LEN = 7;
    localparam int HP_W    = 3;
    localparam int SLEN_W  = 7;
    localparam int CC_W    = 4;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_G      = 8'h47;
    localparam logic [7:0] CHR_P      = 8'h50;
    localparam logic [7:0] CHR_N      = 8'h4E;
    localparam logic [7:0] CHR_R      = 8'h52;
    localparam logic [7:0] CHR_M      = 8'h4D;
    localparam logic [7:0] CHR_C      = 8'h43;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_A      = 8'h41;
    localparam logic [7:0] CHR_V      = 8'h56;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] FID_TIME = 3'd0;
    localparam logic [2:0] FID_LAT  = 3'd1;
    localparam logic [2:0] FID_NS   = 3'd2;
    localparam logic [2:0] FID_LON  = 3'd3;
    localparam logic [2:0] FID_EW   = 3'd4;
    localparam logic [2:0] FID_DATE = 3'd5;

    // comma counts that matter
    localparam logic [CC_W-1:0] CC_STATUS = 4'd1;
    localparam logic [CC_W-1:0] CC_MIN_OK = 4'd9;
    localparam logic [CC_W-1:0] CC_MAX    = 4'd15;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] field_id;
        logic [3:0] char_index;
        logic [7:0] char_code;
        logic       fix_valid;
    } result_t;

    function automatic logic header_match(input logic [HP_W-1:0] pos, input logic [7:0] b);
        logic m;
        begin
            unique case (pos)
                3'd0:    m = (b == CHR_DOLLAR);
                3'd1:    m = (b == CHR_G);
                3'd2:    m = (b == CHR_P) || (b == CHR_N);
                3'd3:    m = (b == CHR_R);
                3'd4:    m = (b == CHR_M);
                3'd5:    m = (b == CHR_C);
                3'd6:    m = (b == CHR_COMMA);
                default: m = 1'b0;
            endcase
            return m;
        end
    endfunction

    // {reported, field id} for a comma count
    function automatic logic [3:0] field_of(input logic [CC_W-1:0] cc);
        logic [3:0] r;
        begin
            unique case (cc)
                4'd0:    r = {1'b1, FID_TIME};
                4'd2:    r = {1'b1, FID_LAT};
                4'd3:    r = {1'b1, FID_NS};
                4'd4:    r = {1'b1, FID_LON};
                4'd5:    r = {1'b1, FID_EW};
                4'd8:    r = {1'b1, FID_DATE};
                default: r = 4'b0000;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/rmc_parse.sv =====
// Input word register and sentence parser state for the RMC extractor.
// While the result slot is free, one byte per cycle is decoded into the
// next state and at most one result. Depends on rmc_pkg.
module rmc_parse #(
    parameter int MAX_SENTENCE = rmc_pkg::MAX_SENTENCE_DEF,
    parameter int FIELD_CHARS  = rmc_pkg::FIELD_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             slot_free,
    output logic             res_load,
    output rmc_pkg::result_t res
);
    import rmc_pkg::*;

    localparam int POS_W = $clog2(FIELD_CHARS + 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             advance;

    logic [HP_W-1:0]   header_pos_reg, header_pos_next;
    logic              in_sentence_reg, in_sentence_next;
    logic [CC_W-1:0]   comma_count_reg, comma_count_next;
    logic [POS_W-1:0]  field_char_pos_reg, field_char_pos_next;
    logic [SLEN_W-1:0] sentence_length_reg, sentence_length_next;
    logic              cr_seen_reg, cr_seen_next;
    logic              position_valid_reg, position_valid_next;

    logic             emit;
    logic [1:0]       kind;
    logic             do_hunt;
    logic [HP_W-1:0]  hunt_pos;
    logic [HP_W-1:0]  hunt_inc;
    logic [3:0]       fsel;
    logic [7:0]       b;

    assign advance  = in_valid_reg && slot_free;
    assign in_ready = !in_valid_reg || advance;
    assign res_load = advance && emit;
    assign b        = in_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    always_comb
    begin
        header_pos_next      = header_pos_reg;
        in_sentence_next     = in_sentence_reg;
        comma_count_next     = comma_count_reg;
        field_char_pos_next  = field_char_pos_reg;
        sentence_length_next = sentence_length_reg;
        cr_seen_next         = cr_seen_reg;
        position_valid_next  = position_valid_reg;
        emit                 = 1'b0;
        kind                 = KIND_CHAR;
        do_hunt              = 1'b0;
        fsel                 = field_of(comma_count_reg);

        if (!in_sentence_reg)
        begin
            do_hunt = 1'b1;
        end
        else if (cr_seen_reg)
        begin
            emit = 1'b1;
            kind = (b == CHR_LF && comma_count_reg >= CC_MIN_OK) ? KIND_OK : KIND_ERR;
            do_hunt = (b != CHR_LF);
        end
        else if (b == CHR_CR)
        begin
            cr_seen_next = 1'b1;
        end
        else if (sentence_length_reg >= SLEN_W'(MAX_SENTENCE))
        begin
            emit    = 1'b1;
            kind    = KIND_ERR;
            do_hunt = 1'b1;
        end
        else
        begin
            sentence_length_next = sentence_length_reg + 1'b1;
            if (b == CHR_COMMA)
            begin
                if (comma_count_reg < CC_MAX)
                begin
                    comma_count_next = comma_count_reg + 1'b1;
                end
                field_char_pos_next = '0;
            end
            else
            begin
                if (field_char_pos_reg < POS_W'(FIELD_CHARS))
                begin
                    field_char_pos_next = field_char_pos_reg + 1'b1;
                end
                if (comma_count_reg == CC_STATUS)
                begin
                    if (field_char_pos_reg == '0 && b == CHR_A)
                    begin
                        position_valid_next = 1'b1;
                    end
                    else if (field_char_pos_reg == '0 && b == CHR_V)
                    begin
                        position_valid_next = 1'b0;
                    end
                end
                else if (fsel[3] && field_char_pos_reg < POS_W'(FIELD_CHARS))
                begin
                    emit = 1'b1;
                end
            end
        end

        // leaving a sentence clears everything but the fix flag
        if (in_sentence_reg && emit && kind != KIND_CHAR)
        begin
            in_sentence_next     = 1'b0;
            header_pos_next      = '0;
            comma_count_next     = '0;
            field_char_pos_next  = '0;
            sentence_length_next = '0;
            cr_seen_next         = 1'b0;
        end

        // header hunt, started from position zero after a sentence ends
        hunt_pos = in_sentence_reg ? '0 : header_pos_reg;
        hunt_inc = hunt_pos + 1'b1;
        if (do_hunt)
        begin
            if (header_match(hunt_pos, b))
            begin
                if (hunt_inc == HP_W'(HDR_LEN))
                begin
                    header_pos_next      = '0;
                    in_sentence_next     = 1'b1;
                    comma_count_next     = '0;
                    field_char_pos_next  = '0;
                    sentence_length_next = SLEN_W'(HDR_LEN);
                    cr_seen_next         = 1'b0;
                end
                else
                begin
                    header_pos_next = hunt_inc;
                end
            end
            else
            begin
                header_pos_next = (b == CHR_DOLLAR) ? HP_W'(1) : '0;
            end
        end
    end

    always_comb
    begin
        res.kind       = kind;
        res.field_id   = (kind == KIND_CHAR) ? fsel[2:0] : '0;
        res.char_index = (kind == KIND_CHAR) ? 4'(field_char_pos_reg) : '0;
        res.char_code  = (kind == KIND_CHAR) ? b : '0;
        res.fix_valid  = position_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg      <= '0;
            in_sentence_reg     <= 1'b0;
            comma_count_reg     <= '0;
            field_char_pos_reg  <= '0;
            sentence_length_reg <= '0;
            cr_seen_reg         <= 1'b0;
            position_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            header_pos_reg      <= header_pos_next;
            in_sentence_reg     <= in_sentence_next;
            comma_count_reg     <= comma_count_next;
            field_char_pos_reg  <= field_char_pos_next;
            sentence_length_reg <= sentence_length_next;
            cr_seen_reg         <= cr_seen_next;
            position_valid_reg  <= position_valid_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sentence_length_reg <= SLEN_W'(MAX_SENTENCE))
        else $error("sentence length past limit");

    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !in_sentence_reg |-> (comma_count_reg == '0 && sentence_length_reg == '0
                              && !cr_seen_reg))
        else $error("sentence state left over while hunting");

    a_hdr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_sentence_reg |-> header_pos_reg == '0)
        else $error("header position nonzero inside sentence");

    a_fix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(position_valid_reg))
        else $error("fix flag changed without a byte");

endmodule

// ===== sv/rmc_out_reg.sv =====
// Result register for the RMC extractor: holds one result word until taken.
// Depends on rmc_pkg.
module rmc_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rmc_pkg::result_t res,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output rmc_pkg::result_t out_res
);
    import rmc_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && load)
        begin
            res_reg <= res;
        end
    end

    a_sentence_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.kind != KIND_CHAR |->
            (res_reg.char_code == '0 && res_reg.char_index == '0 && res_reg.field_id == '0))
        else $error("sentence result carries character data");

    a_load_taken: assert property (@(posedge clk) disable iff (!rst_n)
        slot_free && load |=> valid_reg)
        else $error("result lost on load");

endmodule

// ===== sv/nmea_rmc_field_extractor_unit.sv =====
// Top level of the RMC sentence field extractor: input word register,
// parser, result register. Depends on rmc_pkg, rmc_parse, rmc_out_reg.
//
// Takes one received byte per word and hunts for a "$GPRMC," or "$GNRMC,"
// header. Inside a sentence it emits one character word for each of the first
// FIELD_CHARS characters of the time, latitude, N/S, longitude, E/W and date
// fields, updates the fix flag from the first status character, and ends the
// sentence with an ok word on CR LF after at least nine field commas, or an
// error word otherwise or when the sentence runs past MAX_SENTENCE bytes.
// With the output ready, one byte is taken every cycle; a byte is held in
// the input register and its result is loaded into the result register
// when the result slot is free. The result register and the input register
// together hold one word each while the output is stalled.
module nmea_rmc_field_extractor_unit #(
    parameter int MAX_SENTENCE = rmc_pkg::MAX_SENTENCE_DEF,
    parameter int FIELD_CHARS  = rmc_pkg::FIELD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] field_id, [6:3] char_index,
                                        // [14:7] char_code, [15] fix_valid
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import rmc_pkg::*;

    logic    slot_free;
    logic    res_load;
    result_t res;
    result_t out_res;

    rmc_parse #(
        .MAX_SENTENCE (MAX_SENTENCE),
        .FIELD_CHARS  (FIELD_CHARS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res       (res)
    );

    rmc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {out_res.fix_valid, out_res.char_code,
                           out_res.char_index, out_res.field_id};

endmodule
